### hdl/lbh_pkg.sv
// Package for the letter bigram histogram: shared types, the letter table
// and the letter lookup function. No dependencies.
`default_nettype none

package lbh_pkg;

  // Number of entries in the fixed letter table and the width of an index into it.
  localparam int LETTER_COUNT = 32;
  localparam int LETTER_IW    = 5;

  // Letter table: a to z, then six accented codes of the old PC code page.
  localparam logic [7:0] LETTERS [LETTER_COUNT] = '{
    8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68,
    8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70,
    8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
    8'h79, 8'h7A, 8'h82, 8'h87, 8'h8A, 8'h8C, 8'h93, 8'h96
  };

  typedef struct packed {
    logic                 hit;
    logic [LETTER_IW-1:0] idx;
  } lbh_letter_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } lbh_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic inc_wr;    // write back the incremented pair count
    logic clr_step;  // write zero at the sweep address and advance
    logic scan_rd;   // read the sweep address for the scan and advance
    logic finish;    // clear the winning entry and load the result register
  } lbh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic func;      // the offered item is an extract request
    logic pair_hit;  // the offered character closes a letter pair
    logic swp_last;  // the sweep address is at the last table entry
  } lbh_sts_t;

  function automatic lbh_letter_t letter_lookup(input logic [7:0] code);
    lbh_letter_t res;
    res.hit = 1'b0;
    res.idx = '0;
    for (int i = LETTER_COUNT - 1; i >= 0; i--) begin
      if (LETTERS[i] == code) begin
        res.hit = 1'b1;
        res.idx = LETTER_IW'(i);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/lbh_if.sv
// Channel interfaces of the letter bigram histogram: character/extract input
// and extract result. No dependencies.
`default_nettype none

interface lbh_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] char_code;
  logic       word_end;

  modport source (output valid, func, char_code, word_end, input ready);
  modport sink   (input valid, func, char_code, word_end, output ready);
endinterface

interface lbh_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [4:0]  first_letter;
  logic [4:0]  second_letter;
  logic [31:0] pair_count;
  logic [31:0] chars_total;
  logic [31:0] words_total;

  modport source (output valid, found, first_letter, second_letter, pair_count,
                  chars_total, words_total, input ready);
  modport sink   (input valid, found, first_letter, second_letter, pair_count,
                  chars_total, words_total, output ready);
endinterface

`default_nettype wire

### hdl/lbh_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module lbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/lbh_ctrl.sv
// Controller of the letter bigram histogram: the state machine that sequences
// the clearing pass, pair updates and extract scans. Depends on lbh_pkg.
`default_nettype none

module lbh_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire lbh_pkg::lbh_sts_t sts,
  output lbh_pkg::lbh_cmd_t      cmd
);

  lbh_pkg::lbh_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept;
  logic                slot_free;

  assign in_ready  = (state_r == lbh_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lbh_pkg::ST_CLEAR: begin
        if (sts.swp_last) state_nxt = lbh_pkg::ST_IDLE;
      end
      lbh_pkg::ST_IDLE: begin
        if (accept) begin
          if (sts.func)          state_nxt = lbh_pkg::ST_SCAN;
          else if (sts.pair_hit) state_nxt = lbh_pkg::ST_INC;
        end
      end
      lbh_pkg::ST_INC:   state_nxt = lbh_pkg::ST_IDLE;
      lbh_pkg::ST_SCAN: begin
        if (sts.swp_last) state_nxt = lbh_pkg::ST_DRAIN;
      end
      lbh_pkg::ST_DRAIN: state_nxt = lbh_pkg::ST_FIN;
      lbh_pkg::ST_FIN: begin
        if (slot_free) state_nxt = lbh_pkg::ST_IDLE;
      end
      default: state_nxt = lbh_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    unique case (state_r)
      lbh_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      lbh_pkg::ST_INC:   cmd.inc_wr   = 1'b1;
      lbh_pkg::ST_SCAN:  cmd.scan_rd  = 1'b1;
      lbh_pkg::ST_FIN:   cmd.finish   = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready)  out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbh_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/lbh_datapath.sv
// Datapath of the letter bigram histogram: letter mapping, pairing chain,
// totals, sweep counters, scan maximum and result register. Uses lbh_pkg and
// drives the ports of one lbh_ram.
`default_nettype none

module lbh_datapath #(
  parameter int ALPHABET_SIZE = 32,
  parameter int COUNT_WIDTH   = 32
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire lbh_pkg::lbh_cmd_t                           cmd,
  output lbh_pkg::lbh_sts_t                                sts,
  input  wire logic                                        in_func,
  input  wire logic [7:0]                                  in_char_code,
  input  wire logic                                        in_word_end,
  output logic                                             ram_wr_en,
  output logic [$clog2(ALPHABET_SIZE*ALPHABET_SIZE)-1:0]   ram_wr_addr,
  output logic [COUNT_WIDTH-1:0]                           ram_wr_data,
  output logic                                             ram_rd_en,
  output logic [$clog2(ALPHABET_SIZE*ALPHABET_SIZE)-1:0]   ram_rd_addr,
  input  wire logic [COUNT_WIDTH-1:0]                      ram_rd_data,
  output logic                                             out_found,
  output logic [4:0]                                       out_first_letter,
  output logic [4:0]                                       out_second_letter,
  output logic [31:0]                                      out_pair_count,
  output logic [31:0]                                      out_chars_total,
  output logic [31:0]                                      out_words_total
);

  localparam int DEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(ALPHABET_SIZE);
  localparam int LIW   = lbh_pkg::LETTER_IW;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [31:0] clip32(input logic [COUNT_WIDTH-1:0] v);
    return ((v >> 32) != '0) ? 32'hFFFF_FFFF : 32'(v);
  endfunction

  lbh_pkg::lbh_letter_t lk;
  logic                 letter_ok;
  logic [AW-1:0]        pair_addr;
  logic                 scan_start;
  logic                 swp_step;
  logic                 best_nz;

  logic [LIW-1:0]         prev_r, prev_nxt;
  logic                   prev_is_r, prev_is_nxt;
  logic [COUNT_WIDTH-1:0] chars_r, words_r;
  logic [AW-1:0]          inc_addr_r;
  logic [AW-1:0]          swp_r;
  logic [IW-1:0]          row_r, col_r;
  logic                   cmp_vld_r;
  logic [AW-1:0]          cmp_addr_r;
  logic [IW-1:0]          cmp_row_r, cmp_col_r;
  logic [COUNT_WIDTH-1:0] best_r;
  logic [AW-1:0]          best_addr_r;
  logic [IW-1:0]          best_row_r, best_col_r;

  // Letters beyond the configured alphabet size are treated as non-letters.
  assign lk        = lbh_pkg::letter_lookup(in_char_code);
  assign letter_ok = lk.hit && (int'(lk.idx) < ALPHABET_SIZE);
  assign pair_addr = AW'(prev_r) * AW'(ALPHABET_SIZE) + AW'(lk.idx);

  assign scan_start = cmd.accept && in_func;
  assign swp_step   = cmd.clr_step || cmd.scan_rd;
  assign best_nz    = (best_r != '0);

  assign sts.func     = in_func;
  assign sts.pair_hit = letter_ok && prev_is_r;
  assign sts.swp_last = (swp_r == AW'(DEPTH - 1));

  assign ram_rd_en   = cmd.accept || cmd.scan_rd;
  assign ram_rd_addr = cmd.scan_rd ? swp_r : pair_addr;
  assign ram_wr_en   = cmd.clr_step || cmd.inc_wr || (cmd.finish && best_nz);
  assign ram_wr_addr = cmd.clr_step ? swp_r : (cmd.inc_wr ? inc_addr_r : best_addr_r);
  assign ram_wr_data = cmd.inc_wr ? sat_inc(ram_rd_data) : '0;

  // The pairing chain breaks at a word end and at any non-letter.
  always_comb begin
    prev_nxt    = prev_r;
    prev_is_nxt = prev_is_r;
    if (in_word_end) begin
      prev_nxt    = '0;
      prev_is_nxt = 1'b0;
    end else if (letter_ok) begin
      prev_nxt    = lk.idx;
      prev_is_nxt = 1'b1;
    end else begin
      prev_is_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      prev_is_r <= 1'b0;
      chars_r   <= '0;
      words_r   <= '0;
      swp_r     <= '0;
      row_r     <= '0;
      col_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      if (cmd.accept && !in_func) begin
        prev_r    <= prev_nxt;
        prev_is_r <= prev_is_nxt;
        chars_r   <= sat_inc(chars_r);
        if (in_word_end) words_r <= sat_inc(words_r);
      end
      if (swp_step) begin
        if (sts.swp_last) begin
          swp_r <= '0;
          row_r <= '0;
          col_r <= '0;
        end else begin
          swp_r <= swp_r + 1'b1;
          if (col_r == IW'(ALPHABET_SIZE - 1)) begin
            col_r <= '0;
            row_r <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
      end
      cmp_vld_r <= cmd.scan_rd;
    end
  end

  // Scan maximum: strict compare keeps the first entry on ties.
  always_ff @(posedge clk) begin
    if (cmd.accept) inc_addr_r <= pair_addr;
    if (cmd.scan_rd) begin
      cmp_addr_r <= swp_r;
      cmp_row_r  <= row_r;
      cmp_col_r  <= col_r;
    end
    if (scan_start) begin
      best_r      <= '0;
      best_addr_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else if (cmp_vld_r && (ram_rd_data > best_r)) begin
      best_r      <= ram_rd_data;
      best_addr_r <= cmp_addr_r;
      best_row_r  <= cmp_row_r;
      best_col_r  <= cmp_col_r;
    end
    if (cmd.finish) begin
      out_found         <= best_nz;
      out_first_letter  <= 5'(best_row_r);
      out_second_letter <= 5'(best_col_r);
      out_pair_count    <= clip32(best_r);
      out_chars_total   <= clip32(chars_r);
      out_words_total   <= clip32(words_r);
    end
  end

endmodule

`default_nettype wire

### hdl/letter_bigram_histogram.sv
// Letter bigram histogram. A character item that closes a pair is read from the table RAM,
// then its incremented count is written back. An extract request reads every table entry
// in turn, then its result is loaded into the result register once that register is free.
// One item is in work at a time.
// Reset is synchronous, active low; it is followed by a clearing pass over
// every table entry during which no input is taken.
`default_nettype none

module letter_bigram_histogram #(
  parameter int ALPHABET_SIZE = 32,
  parameter int COUNT_WIDTH   = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  lbh_in_if.sink     in_ch,
  lbh_out_if.source  out_ch
);

  localparam int DEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int AW    = $clog2(DEPTH);

  lbh_pkg::lbh_cmd_t      cmd;
  lbh_pkg::lbh_sts_t      sts;
  logic                   ram_wr_en;
  logic [AW-1:0]          ram_wr_addr;
  logic [COUNT_WIDTH-1:0] ram_wr_data;
  logic                   ram_rd_en;
  logic [AW-1:0]          ram_rd_addr;
  logic [COUNT_WIDTH-1:0] ram_rd_data;

  // The controller owns the handshakes; the result register sits in the
  // datapath, so a finished result can wait while character transfers go on.
  lbh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath maps characters to letters, keeps the pairing chain and
  // totals, walks the table for the clearing pass and the scan, and tracks
  // the largest count seen in the scan.
  lbh_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_ch.func),
    .in_char_code      (in_ch.char_code),
    .in_word_end       (in_ch.word_end),
    .ram_wr_en         (ram_wr_en),
    .ram_wr_addr       (ram_wr_addr),
    .ram_wr_data       (ram_wr_data),
    .ram_rd_en         (ram_rd_en),
    .ram_rd_addr       (ram_rd_addr),
    .ram_rd_data       (ram_rd_data),
    .out_found         (out_ch.found),
    .out_first_letter  (out_ch.first_letter),
    .out_second_letter (out_ch.second_letter),
    .out_pair_count    (out_ch.pair_count),
    .out_chars_total   (out_ch.chars_total),
    .out_words_total   (out_ch.words_total)
  );

  // The pair count table, one entry per ordered pair in row-major order.
  lbh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // At most one source writes the table in any cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_step, cmd.inc_wr, cmd.finish}))
    else $error("table write sources overlap");

  // A result is loaded only when the result register is free or being taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten");

  // No input is taken while the table is being swept.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !(cmd.scan_rd || cmd.clr_step))
    else $error("input taken during a sweep");

  // A scan ends after the last table entry is read.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_rd && sts.swp_last) |=> !cmd.scan_rd)
    else $error("scan ran past the last entry");

endmodule

`default_nettype wire

### sim/lbh_tb_pkg.sv
// Testbench package for the letter bigram histogram: the expected-result
// type, the alphabet helpers and the bigram tally class that predicts and
// checks extract results. Depends on nothing but the simulator.
`timescale 1ns / 100ps

package lbh_tb_pkg;

  localparam int ALPHABET  = 32;
  localparam int TABLE_LEN = ALPHABET * ALPHABET;

  localparam logic FUNC_CHAR    = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  // Bytes of the six accented letters, alphabet indexes 26 to 31.
  localparam logic [7:0] ACCENTED [6] = '{8'h82, 8'h87, 8'h8A, 8'h8C, 8'h93, 8'h96};

  typedef struct packed {
    logic        found;
    logic [4:0]  first_letter;
    logic [4:0]  second_letter;
    logic [31:0] pair_count;
    logic [31:0] chars_total;
    logic [31:0] words_total;
  } extract_result_t;

  // Alphabet index of a byte, or -1 when the byte is not a letter.
  function automatic int letter_slot(logic [7:0] code);
    if (code >= 8'h61 && code <= 8'h7A) return int'(code) - 'h61;
    for (int i = 0; i < 6; i++) begin
      if (ACCENTED[i] == code) return 26 + i;
    end
    return -1;
  endfunction

  function automatic logic [7:0] letter_byte(int idx);
    return (idx < 26) ? 8'(8'h61 + idx) : ACCENTED[idx - 26];
  endfunction

  class bigram_tally;
    logic [31:0]     pair_tally [TABLE_LEN];
    logic [4:0]      last_letter;
    bit              chain_open;
    logic [31:0]     char_tally;
    logic [31:0]     word_tally;
    extract_result_t pending_extracts [$];
    int unsigned     mismatches;

    function new();
      foreach (pair_tally[e]) pair_tally[e] = '0;
      last_letter = '0;
      chain_open  = 1'b0;
      char_tally  = '0;
      word_tally  = '0;
      mismatches  = 0;
    endfunction

    static function logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    function int unsigned outstanding();
      return pending_extracts.size();
    endfunction

    // Updates the tally for one accepted input transfer; an extract request
    // queues the result that the block must return for it.
    function void note_transfer(logic func, logic [7:0] code, logic word_end);
      int              slot;
      int unsigned     at;
      logic [31:0]     best;
      int unsigned     best_at;
      extract_result_t res;
      if (func == FUNC_CHAR) begin
        slot = letter_slot(code);
        if (slot >= 0 && chain_open) begin
          at = int'(last_letter) * ALPHABET + slot;
          pair_tally[at] = bump(pair_tally[at]);
        end
        char_tally = bump(char_tally);
        if (word_end) begin
          word_tally  = bump(word_tally);
          chain_open  = 1'b0;
          last_letter = '0;
        end else if (slot >= 0) begin
          chain_open  = 1'b1;
          last_letter = 5'(slot);
        end else begin
          chain_open = 1'b0;
        end
      end else begin
        best    = '0;
        best_at = 0;
        for (int e = 0; e < TABLE_LEN; e++) begin
          if (pair_tally[e] > best) begin
            best    = pair_tally[e];
            best_at = e;
          end
        end
        res = '0;
        if (best != '0) begin
          pair_tally[best_at] = '0;
          res.found         = 1'b1;
          res.first_letter  = 5'(best_at / ALPHABET);
          res.second_letter = 5'(best_at % ALPHABET);
          res.pair_count    = best;
        end
        res.chars_total = char_tally;
        res.words_total = word_tally;
        pending_extracts.push_back(res);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_extract(extract_result_t got);
      extract_result_t want;
      if (pending_extracts.size() == 0) begin
        $error("extract result arrived with no extract request pending");
        mismatches++;
        return;
      end
      want = pending_extracts.pop_front();
      compare_field("found", want.found, got.found);
      compare_field("first_letter", want.first_letter, got.first_letter);
      compare_field("second_letter", want.second_letter, got.second_letter);
      compare_field("pair_count", want.pair_count, got.pair_count);
      compare_field("chars_total", want.chars_total, got.chars_total);
      compare_field("words_total", want.words_total, got.words_total);
    endfunction
  endclass

endpackage

### sim/letter_bigram_histogram_tb.sv
// Top-level testbench of the letter bigram histogram: drives word characters
// and extract requests, and checks every extract result. Depends on
// letter_bigram_histogram, the channel interfaces in lbh_if and lbh_tb_pkg.
`timescale 1ns / 100ps

module letter_bigram_histogram_tb;

  // Even if every item sent were an extract request, a correct run would stay
  // well under this limit, counting a full table scan per extract, the clearing
  // pass after reset and the receiver stalls.
  localparam int unsigned CYCLE_LIMIT  = 10_000_000;
  // This covers one more extract scan after the last expected result, in case
  // a stray result shows up.
  localparam int          DRAIN_CYCLES = 1100;
  localparam int          PHASE_ITEMS  = 530;

  logic clk;
  logic rst_n;

  lbh_in_if  in_ch ();
  lbh_out_if out_ch ();

  letter_bigram_histogram dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lbh_tb_pkg::bigram_tally tally = new();

  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned items_sent   = 0;
  int unsigned cycle_count  = 0;

  // Letters that most words of a phase are built from, so that some pairs
  // pile up real counts and the extracts have a meaningful order to return.
  int focus [6];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that hangs or loses results ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL letter_bigram_histogram");
      $finish;
    end
  end

  // The receiver changes ready at the falling edge; with out_idle_pct at zero
  // it is always ready.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // A result transfer happens at a rising edge with valid and ready both high.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tally.check_extract({out_ch.found, out_ch.first_letter, out_ch.second_letter,
                           out_ch.pair_count, out_ch.chars_total, out_ch.words_total});
    end
  end

  // Offers one item, entered and left at a falling edge. Before the item the
  // sender may idle for a few cycles. Valid is not lowered after the transfer;
  // the next call either idles or presents the next item at the same edge, so
  // valid gets a single assignment per time step.
  task automatic send_item(input logic func, input logic [7:0] code, input logic word_end);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.char_code <= code;
    in_ch.word_end  <= word_end;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tally.note_transfer(func, code, word_end);
    items_sent++;
    @(negedge clk);
  endtask

  // The byte and word-end flag of an extract request are ignored by the
  // block, so they carry random values.
  task automatic request_extract();
    send_item(lbh_tb_pkg::FUNC_EXTRACT, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // The sender stops until every pending extract has returned its result.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (tally.outstanding() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(99) < 70) return lbh_tb_pkg::letter_byte(focus[$urandom_range(5)]);
    return lbh_tb_pkg::letter_byte($urandom_range(lbh_tb_pkg::ALPHABET - 1));
  endfunction

  // A word of mostly letters, now and then a raw byte that breaks the chain.
  // A few words lose their end flag, so the chain runs on into the next word.
  task automatic send_word();
    int          len;
    logic [7:0]  code;
    logic        last;
    len = $urandom_range(1, ($urandom_range(9) == 0) ? 20 : 6);
    for (int i = 0; i < len; i++) begin
      code = ($urandom_range(99) < 10) ? 8'($urandom_range(255)) : pick_letter();
      last = (i == len - 1) && ($urandom_range(99) >= 5);
      send_item(lbh_tb_pkg::FUNC_CHAR, code, last);
    end
  endtask

  // Random traffic: mostly well-formed words, some single raw bytes with a
  // random end flag, and short bursts of extract requests.
  task automatic run_phase(input int unsigned in_pct, input int unsigned out_pct);
    int unsigned target;
    int unsigned pick;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    target       = items_sent + PHASE_ITEMS;
    foreach (focus[i]) focus[i] = $urandom_range(lbh_tb_pkg::ALPHABET - 1);
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        send_word();
      end else if (pick < 90) begin
        send_item(lbh_tb_pkg::FUNC_CHAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(1, 3)) request_extract();
      end
    end
    wait_quiet();
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.func      = lbh_tb_pkg::FUNC_CHAR;
    in_ch.char_code = '0;
    in_ch.word_end  = 1'b0;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // The block clears its table after reset and holds ready low meanwhile;
    // the first transfer simply waits for it.
    @(negedge clk);

    // Directed part, with an eager sender and a receiver that stalls half the time.
    out_idle_pct = 50;
    // Extract from the empty table right after reset, with both ignored fields set.
    send_item(lbh_tb_pkg::FUNC_EXTRACT, 8'hFF, 1'b1);
    // First and last letter of the alphabet form a pair; an extract in the
    // middle of a word must leave the chain open, so the accented letter
    // that follows still pairs with the last one.
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h61, 1'b0);
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h96, 1'b0);
    request_extract();
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h82, 1'b1);
    // Byte zero breaks the chain: z and b must not pair.
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h7A, 1'b0);
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h00, 1'b0);
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h62, 1'b0);
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h61, 1'b0);
    // A non-letter ends the word.
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'hFF, 1'b1);
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h61, 1'b0);
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h62, 1'b1);
    // Three pairs tie at one; they must come out in row-major order, then
    // the table is empty twice over.
    repeat (5) request_extract();
    wait_quiet();
    // Bytes just outside the letter ranges, then a doubled letter and a pair
    // of accented letters, with the word spanning no word boundary.
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h60, 1'b0);
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h7A, 1'b0);
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h7A, 1'b0);
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h7B, 1'b0);
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h81, 1'b0);
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h87, 1'b0);
    send_item(lbh_tb_pkg::FUNC_CHAR, 8'h8A, 1'b1);
    request_extract();
    wait_quiet();

    // Random part: idle receiver first, then idle sender, then no idling.
    run_phase(31, 67);
    run_phase(67, 31);
    run_phase(0, 0);

    // Every expected result is in; give the block time to show a stray one.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tally.mismatches == 0 && tally.outstanding() == 0) begin
      $display("PASS letter_bigram_histogram");
    end else begin
      $display("FAIL letter_bigram_histogram");
    end
    $finish;
  end

endmodule

### letter_bigram_histogram.f
hdl/lbh_pkg.sv
hdl/lbh_if.sv
hdl/lbh_ram.sv
hdl/lbh_ctrl.sv
hdl/lbh_datapath.sv
hdl/letter_bigram_histogram.sv
sim/lbh_tb_pkg.sv
sim/letter_bigram_histogram_tb.sv
